### rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants for the strongly connected component finder
// Sequencer states and the fixed widths of the port fields.
// ----------------------------------------------------------------------------
package tsf_pkg;

	// fixed widths of the port fields
	localparam int NODE_W = 6;
	localparam int CNT_W  = 7;

	// search sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROOT,
		ST_HEAD,
		ST_EDGE,
		ST_EDGE_RD,
		ST_LOW_RD,
		ST_CLOSE,
		ST_POP_RD,
		ST_POP,
		ST_ENDV,
		ST_FRAME_RD,
		ST_FLUSH
	} state_t;

endpackage

### rtl/tarjan_scc_finder.sv
// ----------------------------------------------------------------------------
// tarjan_scc_finder: strongly connected components of a loaded directed graph
// Edges are stored as per-source linked lists; the item marked last starts an
// iterative Tarjan search with explicit node and frame stacks in memory.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | src_node, dst_node, edge_valid, last_item
//  out     | out_valid / out_ready| node_id, component_index, component_end,
//          |                      | last_result
//  cfg     | cfg_we               | cfg_wdata (node_count)
//
// An edge request does a tail pointer read, then a list append.
// The search runs one sequencer step per cycle: a node visit fetches its
// head, checks the list end, closes and unwinds its frame; an edge reads
// its target, then its low link if the target is on the stack; a popped
// node waits until the output keeps up. Input is held off until done.
// The last result waits in a holding register so its last flag is known.
// Reset clears control state; edge memory needs no clearing pass.
// ----------------------------------------------------------------------------
module tarjan_scc_finder
	import tsf_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NODE_W-1:0] src_node,
	input  logic [NODE_W-1:0] dst_node,
	input  logic              edge_valid,
	input  logic              last_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] node_id,
	output logic [NODE_W-1:0] component_index,
	output logic              component_end,
	output logic              last_result
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	typedef struct packed {
		logic [NW-1:0]  v;
		logic [EAW-1:0] e;
		logic           enull;
		logic [EAW-1:0] tail;
		logic [NW-1:0]  ord;
		logic [NW-1:0]  low;
	} frame_t;

	// memories
	logic [NW-1:0]  tgt_mem  [MAX_EDGES];
	logic [EAW-1:0] nxt_mem  [MAX_EDGES];
	logic [EAW-1:0] head_mem [MAX_NODES];
	logic [EAW-1:0] tail_mem [MAX_NODES];
	logic [NW-1:0]  low_mem  [MAX_NODES];
	logic [NW-1:0]  nstk_mem [MAX_NODES];
	frame_t         frm_mem  [MAX_NODES];

	// control state
	state_t         state_q, state_d;
	logic [CNT_W-1:0] node_count_q;
	logic [ECW-1:0] edges_q;
	logic [MAX_NODES-1:0] head_vld_q, visited_q, onstk_q;
	logic [CNT_W-1:0] vc_q, comp_q, sp_q, fp_q, root_q;
	logic           out_vld_q, pend_vld_q;

	// item and datapath registers
	logic [NW-1:0]  src_q, dst_q;
	logic           store_q, last_q;
	logic [NW-1:0]  cur_v_q, cur_ord_q, cur_low_q;
	logic [EAW-1:0] cur_e_q, cur_tail_q;
	logic           cur_enull_q;
	logic [NW-1:0]  pend_node_q, pend_comp_q;
	logic           pend_end_q;
	logic [NODE_W-1:0] out_node_q, out_comp_q;
	logic           out_end_q, out_last_q;

	// registered read data
	logic [EAW-1:0] head_rd_q, tail_rd_q, nxt_rd_q;
	logic [NW-1:0]  tgt_rd_q, low_rd_q, nstk_rd_q;
	frame_t         frm_rd_q;

	logic [CNT_W-1:0] n_eff;
	logic           in_ok, accept, store_now;
	logic           w_ok, nxt_null, visit_root, visit_child, do_visit;
	logic [NW-1:0]  vis_node, root_idx, w;
	logic           slot_free, emit, flush_mv, pop_done;
	logic [NW-1:0]  tail_raddr;
	frame_t         push_frame;
	logic           low_we;
	logic [NW-1:0]  low_waddr, low_wdata;

	// effective node count and request acceptance
	assign n_eff    = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_ok    = (CNT_W'(src_node) < n_eff) && (CNT_W'(dst_node) < n_eff);
	assign store_now = edge_valid && in_ok && (edges_q < ECW'(MAX_EDGES));

	// search step decodes
	assign w          = tgt_rd_q;
	assign w_ok       = CNT_W'(w) < n_eff;
	assign nxt_null   = (cur_e_q == cur_tail_q);
	assign root_idx   = root_q[NW-1:0];
	assign visit_root = (state_q == ST_ROOT) && (root_q < n_eff) && !visited_q[root_idx];
	assign visit_child = (state_q == ST_EDGE_RD) && w_ok && !visited_q[w];
	assign do_visit   = visit_root || visit_child;
	assign vis_node   = visit_root ? root_idx : w;
	assign slot_free  = !out_vld_q || out_ready;
	assign emit       = (state_q == ST_POP) && (!pend_vld_q || slot_free);
	assign pop_done   = (nstk_rd_q == cur_v_q);
	assign flush_mv   = (state_q == ST_FLUSH) && pend_vld_q && slot_free;
	assign tail_raddr = (state_q == ST_IDLE) ? src_node[NW-1:0] : vis_node;

	assign push_frame = '{v: cur_v_q, e: nxt_rd_q, enull: nxt_null, tail: cur_tail_q,
		ord: cur_ord_q, low: cur_low_q};

	// low link write: when the top node is pushed down or finished
	assign low_we    = visit_child || (state_q == ST_ENDV);
	assign low_waddr = cur_v_q;
	assign low_wdata = cur_low_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept) state_d = ST_LOAD;
			ST_LOAD:     state_d = last_q ? ST_ROOT : ST_IDLE;
			ST_ROOT: begin
				if (root_q >= n_eff) state_d = ST_FLUSH;
				else if (visit_root) state_d = ST_HEAD;
			end
			ST_HEAD:     state_d = ST_EDGE;
			ST_EDGE:     state_d = cur_enull_q ? ST_CLOSE : ST_EDGE_RD;
			ST_EDGE_RD: begin
				if (!w_ok) state_d = ST_EDGE;
				else if (!visited_q[w]) state_d = ST_HEAD;
				else if (onstk_q[w] && (w != cur_v_q)) state_d = ST_LOW_RD;
				else state_d = ST_EDGE;
			end
			ST_LOW_RD:   state_d = ST_EDGE;
			ST_CLOSE:    state_d = (cur_low_q == cur_ord_q) ? ST_POP_RD : ST_ENDV;
			ST_POP_RD:   state_d = ST_POP;
			ST_POP:      if (emit) state_d = pop_done ? ST_ENDV : ST_POP_RD;
			ST_ENDV:     state_d = (fp_q == '0) ? ST_ROOT : ST_FRAME_RD;
			ST_FRAME_RD: state_d = ST_EDGE;
			ST_FLUSH:    if (!pend_vld_q || flush_mv) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// output port drive
	always_comb begin
		out_valid       = out_vld_q;
		node_id         = out_node_q;
		component_index = out_comp_q;
		component_end   = out_end_q;
		last_result     = out_last_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= CNT_W'(64);
			edges_q      <= '0;
			head_vld_q   <= '0;
			visited_q    <= '0;
			onstk_q      <= '0;
			vc_q         <= '0;
			comp_q       <= '0;
			sp_q         <= '0;
			fp_q         <= '0;
			root_q       <= '0;
			out_vld_q    <= 1'b0;
			pend_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) node_count_q <= cfg_wdata;
			// output register holds until taken; refilled from the holding register
			out_vld_q <= (out_vld_q && !out_ready) || ((emit || flush_mv) && pend_vld_q);
			case (state_q)
				ST_LOAD: begin
					if (store_q) begin
						head_vld_q[src_q] <= 1'b1;
						edges_q <= edges_q + ECW'(1);
					end
					if (last_q) begin
						visited_q <= '0;
						onstk_q   <= '0;
						vc_q      <= '0;
						comp_q    <= '0;
						sp_q      <= '0;
						fp_q      <= '0;
						root_q    <= '0;
					end
				end
				ST_ROOT: if (!visit_root && root_q < n_eff) root_q <= root_q + CNT_W'(1);
				ST_EDGE_RD: if (visit_child) fp_q <= fp_q + CNT_W'(1);
				ST_POP_RD: sp_q <= sp_q - CNT_W'(1);
				ST_POP: begin
					if (emit) begin
						onstk_q[nstk_rd_q] <= 1'b0;
						pend_vld_q <= 1'b1;
						if (pop_done) comp_q <= comp_q + CNT_W'(1);
					end
				end
				ST_ENDV: if (fp_q != '0) fp_q <= fp_q - CNT_W'(1);
				ST_FLUSH: begin
					if (flush_mv) pend_vld_q <= 1'b0;
					if (!pend_vld_q || flush_mv) begin
						head_vld_q <= '0;
						edges_q    <= '0;
					end
				end
				default: ;
			endcase
			if (do_visit) begin
				visited_q[vis_node] <= 1'b1;
				onstk_q[vis_node]   <= 1'b1;
				vc_q <= vc_q + CNT_W'(1);
				sp_q <= sp_q + CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q   <= src_node[NW-1:0];
			dst_q   <= dst_node[NW-1:0];
			store_q <= store_now;
			last_q  <= last_item;
		end
		if (do_visit) begin
			cur_v_q   <= vis_node;
			cur_ord_q <= vc_q[NW-1:0];
			cur_low_q <= vc_q[NW-1:0];
		end
		case (state_q)
			ST_HEAD: begin
				cur_e_q     <= head_rd_q;
				cur_tail_q  <= tail_rd_q;
				cur_enull_q <= !head_vld_q[cur_v_q];
			end
			ST_EDGE_RD: begin
				if (!visit_child) begin
					cur_e_q     <= nxt_rd_q;
					cur_enull_q <= nxt_null;
				end
			end
			ST_LOW_RD: if (low_rd_q < cur_low_q) cur_low_q <= low_rd_q;
			ST_FRAME_RD: begin
				cur_v_q     <= frm_rd_q.v;
				cur_e_q     <= frm_rd_q.e;
				cur_enull_q <= frm_rd_q.enull;
				cur_tail_q  <= frm_rd_q.tail;
				cur_ord_q   <= frm_rd_q.ord;
				cur_low_q   <= (onstk_q[cur_v_q] && cur_low_q < frm_rd_q.low) ?
					cur_low_q : frm_rd_q.low;
			end
			default: ;
		endcase
		// result holding register feeds the output register
		if (emit || flush_mv) begin
			if (pend_vld_q) begin
				out_node_q <= NODE_W'(pend_node_q);
				out_comp_q <= NODE_W'(pend_comp_q);
				out_end_q  <= pend_end_q;
				out_last_q <= flush_mv;
			end
		end
		if (emit) begin
			pend_node_q <= nstk_rd_q;
			pend_comp_q <= comp_q[NW-1:0];
			pend_end_q  <= pop_done;
		end
	end

	// edge memories
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && store_q) begin
			tgt_mem[edges_q[EAW-1:0]] <= dst_q;
			if (head_vld_q[src_q]) nxt_mem[tail_rd_q] <= edges_q[EAW-1:0];
		end
		if (state_q == ST_EDGE) begin
			tgt_rd_q <= tgt_mem[cur_e_q];
			nxt_rd_q <= nxt_mem[cur_e_q];
		end
	end

	// list head and tail memories
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && store_q) begin
			tail_mem[src_q] <= edges_q[EAW-1:0];
			if (!head_vld_q[src_q]) head_mem[src_q] <= edges_q[EAW-1:0];
		end
		tail_rd_q <= tail_mem[tail_raddr];
		head_rd_q <= head_mem[vis_node];
	end

	// low link memory
	always_ff @(posedge clk) begin
		if (low_we) low_mem[low_waddr] <= low_wdata;
		low_rd_q <= low_mem[w];
	end

	// node stack memory
	always_ff @(posedge clk) begin
		if (do_visit) nstk_mem[sp_q[NW-1:0]] <= vis_node;
		if (state_q == ST_POP_RD) nstk_rd_q <= nstk_mem[sp_q[NW-1:0] - NW'(1)];
	end

	// frame stack memory
	always_ff @(posedge clk) begin
		if (visit_child) frm_mem[fp_q[NW-1:0]] <= push_frame;
		if (state_q == ST_ENDV) frm_rd_q <= frm_mem[fp_q[NW-1:0] - NW'(1)];
	end

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CNT_W'(MAX_NODES))
		else $error("node stack overflow");

	a_frames_below_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDGE) |-> (fp_q < sp_q))
		else $error("frame depth exceeds node stack depth");

	a_last_ends_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_last_q) |-> out_end_q)
		else $error("final result does not close a component");

	a_edges_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edges_q <= ECW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (pend_vld_q || state_q == ST_IDLE ||
			state_q == ST_FLUSH))
		else $error("flush left unexpected state");
`endif

endmodule
